// File: hdl/fltr_pkg.sv
// ----------------------------------------------------------------------------
// fltr_pkg
// Shared types and constants for the fix layer tile row renderer.
// ----------------------------------------------------------------------------
package fltr_pkg;

  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = 8;
  localparam int COLOUR_W    = 16;
  localparam int PIX_PER_ROW = 8;
  localparam int PIX_CNT_W   = 3;
  localparam int NIBBLE_W    = 4;

  localparam int DEF_SCREEN_COLS = 40;
  localparam int DEF_SCREEN_ROWS = 28;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_DRAW      = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                en;
    logic [PAL_AW-1:0]   addr;
    logic [COLOUR_W-1:0] data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

endpackage

// File: hdl/fix_layer_tile_row_renderer.sv
// ----------------------------------------------------------------------------
// fix_layer_tile_row_renderer
// Renders one row of one 8x8 fix layer tile per draw transfer.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the command. A palette write stores one 16-bit
// colour and gives no output; a draw gives eight pixel transfers, leftmost
// pixel first, tlast on the eighth.
// Items pass through one item register and are executed in order, so a
// palette write always follows every read of the draws before it.
// The first pixel of a draw passes through the item register and the output
// register. A draw holds the item register, reading one palette entry per
// pixel on its one read port, one pixel per cycle unless the receiver stalls.
// The next item is accepted in the cycle the current one finishes.
// When the receiver stalls, the output register holds its pixel and the
// draw in progress waits; a new item is still taken once the item register
// frees up. Reset empties both registers and makes every palette entry read
// as zero at once, with no clearing pass.
// Tiles outside SCREEN_COLS x SCREEN_ROWS still emit eight pixels, all with
// write enable low.
// ----------------------------------------------------------------------------
module fix_layer_tile_row_renderer #(
  parameter int SCREEN_COLS = fltr_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = fltr_pkg::DEF_SCREEN_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pal_index[7:0] pal_value[23:8] tile_word[39:24] row_pixels[71:40]
  // tile_col[77:72] tile_row[82:78] line_in_tile[85:83], zero pad
  input  logic [fltr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_x[8:0] pixel_y[16:9] pixel_colour[32:17], zero pad
  output logic [fltr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // write_enable[0]
  output logic                             m_axis_tuser,
  // last_pixel
  output logic                             m_axis_tlast
);

  localparam logic [fltr_pkg::PIX_CNT_W-1:0] LastPix =
    fltr_pkg::PIX_CNT_W'(fltr_pkg::PIX_PER_ROW - 1);

  // item register
  logic                            a_valid;
  fltr_pkg::cmd_t                  a_cmd;
  logic [fltr_pkg::PAL_AW-1:0]     a_pal_index;
  logic [fltr_pkg::COLOUR_W-1:0]   a_pal_value;
  logic [3:0]                      a_bank;
  logic [31:0]                     a_pixels;
  logic [5:0]                      a_col;
  logic [4:0]                      a_row;
  logic [2:0]                      a_line;
  logic [fltr_pkg::PIX_CNT_W-1:0]  a_cnt;

  // output register
  logic                            b_valid;
  logic [8:0]                      b_x;
  logic [7:0]                      b_y;
  logic                            b_we;
  logic                            b_last;
  logic [fltr_pkg::COLOUR_W-1:0]   b_colour;

  logic                            advance;
  logic                            a_done;
  logic                            on_screen;
  logic [fltr_pkg::NIBBLE_W-1:0]   nibble;
  logic                            in_xfer;
  fltr_pkg::pal_wr_t               pal_wr;
  fltr_pkg::pal_rd_t               pal_rd;

  assign on_screen = (int'(a_col) < SCREEN_COLS) && (int'(a_row) < SCREEN_ROWS);
  assign nibble    = a_pixels[{a_cnt, 2'b00} +: fltr_pkg::NIBBLE_W];
  assign advance   = a_valid && (a_cmd == fltr_pkg::CMD_DRAW) &&
                     (!b_valid || m_axis_tready);
  assign a_done    = a_valid && ((a_cmd == fltr_pkg::CMD_PAL_WRITE) ||
                                 (advance && (a_cnt == LastPix)));
  assign s_axis_tready = !a_valid || a_done;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign pal_wr.en   = a_valid && (a_cmd == fltr_pkg::CMD_PAL_WRITE);
  assign pal_wr.addr = a_pal_index;
  assign pal_wr.data = a_pal_value;
  assign pal_rd.en   = advance;
  assign pal_rd.addr = {a_bank, nibble};

  fltr_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (b_colour)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_cnt   <= '0;
    end else begin
      if (in_xfer) begin
        a_valid <= 1'b1;
        a_cnt   <= '0;
      end else if (a_done) begin
        a_valid <= 1'b0;
        a_cnt   <= '0;
      end else if (advance) begin
        a_cnt <= a_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_cmd       <= fltr_pkg::cmd_t'(s_axis_tuser);
      a_pal_index <= s_axis_tdata[7:0];
      a_pal_value <= s_axis_tdata[23:8];
      a_bank      <= s_axis_tdata[39:36];
      a_pixels    <= s_axis_tdata[71:40];
      a_col       <= s_axis_tdata[77:72];
      a_row       <= s_axis_tdata[82:78];
      a_line      <= s_axis_tdata[85:83];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= 1'b1;
    end else if (m_axis_tready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_x    <= {a_col, a_cnt};
      b_y    <= {a_row, a_line};
      b_we   <= (nibble != '0) && on_screen;
      b_last <= (a_cnt == LastPix);
    end
  end

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {7'd0, b_colour, b_y, b_x};
  assign m_axis_tuser  = b_we;
  assign m_axis_tlast  = b_last;

`ifndef SYNTH
  a_cnt_only_in_draw: assert property (@(posedge clk) disable iff (rst)
    (a_cnt != '0) |-> (a_valid && (a_cmd == fltr_pkg::CMD_DRAW)))
    else $error("pixel counter running outside a draw");

  empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_axis_tready)
    else $error("empty item register refuses input");

  last_at_row_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd7)))
    else $error("tlast does not match pixel position");

  pal_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (a_valid && (a_cmd == fltr_pkg::CMD_PAL_WRITE)) |-> s_axis_tready)
    else $error("palette write did not retire in one cycle");
`endif

endmodule

// File: hdl/fltr_palette.sv
// ----------------------------------------------------------------------------
// fltr_palette
// 256 x 16 palette RAM, one write and one registered read port. Entries
// never written since reset read as zero through a per-entry valid bit.
// ----------------------------------------------------------------------------
module fltr_palette (
  input  logic                          clk,
  input  logic                          rst,
  input  fltr_pkg::pal_wr_t             wr,
  input  fltr_pkg::pal_rd_t             rd,
  output logic [fltr_pkg::COLOUR_W-1:0] rd_data
);

  logic [fltr_pkg::COLOUR_W-1:0]  mem [fltr_pkg::PAL_DEPTH];
  logic [fltr_pkg::PAL_DEPTH-1:0] written;
  logic [fltr_pkg::COLOUR_W-1:0]  rd_reg;
  logic                           rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_reg <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_hit <= written[rd.addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_reg : '0;

endmodule
